// ===== rtl/indexed_min_heap_timer_queue_core_assert.svh =====
// ----------------------------------------------------------------------------
// Timer queue assertion macros
// Shared property forms for the timer queue checks (clk / arst_n domain).
// ----------------------------------------------------------------------------
`ifndef INDEXED_MIN_HEAP_TIMER_QUEUE_CORE_ASSERT_SVH
`define INDEXED_MIN_HEAP_TIMER_QUEUE_CORE_ASSERT_SVH

// same-cycle implication
`define IMHTQ_ASSERT_IMP(name, cond, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("timer queue check failed");

// next-cycle implication
`define IMHTQ_ASSERT_NXT(name, cond, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("timer queue check failed");

`endif

// ===== rtl/imhtq_pkg.sv =====
// ----------------------------------------------------------------------------
// Timer queue package
// Operation and result codes, entry types and the wrap-aware time compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package imhtq_pkg;

	localparam int HEAP_CAPACITY_DEF = 64;
	localparam int ID_COUNT_DEF      = 1024;
	localparam int MAX_IDS           = 1024;

	localparam int OP_W      = 3;
	localparam int ID_W      = 10;
	localparam int TIMEOUT_W = 31;
	localparam int TIME_W    = 32;
	localparam int KIND_W    = 3;

	localparam logic [OP_W-1:0] OP_ADD   = 3'd0;
	localparam logic [OP_W-1:0] OP_ADJ   = 3'd1;
	localparam logic [OP_W-1:0] OP_FIRE  = 3'd2;
	localparam logic [OP_W-1:0] OP_TICK  = 3'd3;
	localparam logic [OP_W-1:0] OP_QUERY = 3'd4;
	localparam logic [OP_W-1:0] OP_CLEAR = 3'd5;

	localparam logic [KIND_W-1:0] KIND_DONE    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_FIRED   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_DELAY   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_FULL    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_UNKNOWN = 3'd4;

	typedef struct packed {
		logic [TIME_W-1:0] expiry;
		logic [ID_W-1:0]   owner;
	} entry_t;

	typedef struct packed {
		logic [KIND_W-1:0]    kind;
		logic [ID_W-1:0]      id;
		logic [TIMEOUT_W-1:0] delay;
		logic                 empty;
	} res_t;

	// a is earlier than b when the wrapped difference is negative
	function automatic logic earlier(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
		logic [TIME_W-1:0] d;
		d = a - b;
		return d[TIME_W-1];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/imhtq_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module imhtq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/imhtq_level.sv =====
// ----------------------------------------------------------------------------
// Heap level cell
// Holds one level of the heap as sibling pairs; reads a pair, writes one slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module imhtq_level #(
	parameter int SIZE = 1,
	parameter int LOCW = 1
) (
	input  logic               clk,
	input  logic               wr_en,
	input  logic [LOCW-1:0]    wr_loc,
	input  imhtq_pkg::entry_t  wr_data,
	input  logic [LOCW-1:0]    rd_loc,
	output imhtq_pkg::entry_t  rd_even,
	output imhtq_pkg::entry_t  rd_odd
);
	import imhtq_pkg::*;

	localparam int ROWS = (SIZE + 1) / 2;
	localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

	entry_t          even_q [ROWS];
	entry_t          odd_q  [ROWS];
	logic [LOCW-1:0] rd_shift;
	logic [LOCW-1:0] wr_shift;
	logic [RW-1:0]   rd_row;
	logic [RW-1:0]   wr_row;

	assign rd_shift = rd_loc >> 1;
	assign wr_shift = wr_loc >> 1;
	assign rd_row   = rd_shift[RW-1:0];
	assign wr_row   = wr_shift[RW-1:0];

	// store one slot of the pair
	always_ff @(posedge clk) begin
		if (wr_en) begin
			if (wr_loc[0]) begin
				odd_q[wr_row] <= wr_data;
			end else begin
				even_q[wr_row] <= wr_data;
			end
		end
	end

	// present the addressed sibling pair
	assign rd_even = even_q[rd_row];
	assign rd_odd  = odd_q[rd_row];

endmodule

`default_nettype wire

// ===== rtl/indexed_min_heap_timer_queue_core.sv =====
// ----------------------------------------------------------------------------
// Indexed min-heap timer queue
// Binary min-heap of timers by wrap-aware expiry, with an id to slot map.
// ----------------------------------------------------------------------------
// Usage: drive operation, timer_id, timeout_ms and now_ms with start; the
// item is taken on a clock edge where start is high and busy is low. Each
// result appears for one cycle with result_strobe high; last marks the final
// result of the item. Results cannot be held off by the receiver, so no
// stall ever reaches the heap.
// Items run one at a time. Add, adjust and fire walk the heap one level per
// cycle through a row of level cells; tick and query pop the expired timers
// one by one; clear and unused codes need no heap walk.
// Busy falls in the cycle that carries the last result, so the next item can
// be taken there.
// Reset empties the queue at once; heap slots and the id to slot map need no
// clearing, since an id counts as queued only when its mapped slot lies
// below the entry count and holds that id.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "indexed_min_heap_timer_queue_core_assert.svh"

module indexed_min_heap_timer_queue_core #(
	parameter int HEAP_CAPACITY = imhtq_pkg::HEAP_CAPACITY_DEF,
	parameter int ID_COUNT      = imhtq_pkg::ID_COUNT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [imhtq_pkg::OP_W-1:0]      operation,
	input  logic [imhtq_pkg::ID_W-1:0]      timer_id,
	input  logic [imhtq_pkg::TIMEOUT_W-1:0] timeout_ms,
	input  logic [imhtq_pkg::TIME_W-1:0]    now_ms,
	output logic                           result_strobe,
	output logic [imhtq_pkg::KIND_W-1:0]    kind,
	output logic [imhtq_pkg::ID_W-1:0]      out_id,
	output logic [imhtq_pkg::TIMEOUT_W-1:0] delay_ms,
	output logic                           queue_empty,
	output logic                           last
);
	import imhtq_pkg::*;

	localparam int POSW     = $clog2(HEAP_CAPACITY);
	localparam int CNTW     = $clog2(HEAP_CAPACITY + 1);
	localparam int LEVELS   = CNTW;
	localparam int LVLW     = $clog2(LEVELS);
	localparam int LOCW     = LEVELS - 1;
	localparam int CGW      = POSW + 2;
	localparam int ID_DEPTH = (ID_COUNT < MAX_IDS) ? ID_COUNT : MAX_IDS;
	localparam int IDW      = $clog2(ID_DEPTH);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOOK = 3'd1;
	localparam logic [2:0] ST_REM  = 3'd2;
	localparam logic [2:0] ST_SD   = 3'd3;
	localparam logic [2:0] ST_SU   = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;
	localparam logic [2:0] ST_POP  = 3'd6;
	localparam logic [2:0] ST_DONE = 3'd7;

	localparam logic [1:0] AFT_DONE = 2'd0;
	localparam logic [1:0] AFT_FIRE = 2'd1;
	localparam logic [1:0] AFT_POP  = 2'd2;

	// slot index to heap level
	function automatic logic [LVLW-1:0] lvl_of(input logic [POSW-1:0] g);
		logic [CNTW-1:0] v;
		logic [LVLW-1:0] l;
		v = CNTW'(g) + CNTW'(1);
		l = '0;
		for (int b = 0; b < CNTW; b++) begin
			if (v[b]) begin
				l = LVLW'(b);
			end
		end
		return l;
	endfunction

	// slot index to place within its level
	function automatic logic [LOCW-1:0] loc_of(input logic [POSW-1:0] g,
		input logic [LVLW-1:0] l);
		logic [CNTW-1:0] v;
		v = CNTW'(g) + CNTW'(1) - (CNTW'(1) << l);
		return v[LOCW-1:0];
	endfunction

	logic [2:0]          state_q, state_d;
	logic [OP_W-1:0]     op_q, op_d;
	logic [ID_W-1:0]     id_q, id_d;
	logic [TIME_W-1:0]   exp_q, exp_d;
	logic [TIME_W-1:0]   now_q, now_d;
	logic                idok_q, idok_d;
	entry_t              e_q, e_d;
	logic [CNTW-1:0]     cnt_q, cnt_d;
	logic [POSW-1:0]     g_q, g_d;
	logic [LVLW-1:0]     lvl_q, lvl_d;
	logic [LOCW-1:0]     loc_q, loc_d;
	logic                moved_q, moved_d;
	logic [1:0]          after_q, after_d;
	logic [ID_W-1:0]     fid_q, fid_d;

	logic [LVLW-1:0]     rd_lvl;
	logic [LOCW-1:0]     rd_loc;
	logic                wr_en;
	logic [LVLW-1:0]     wr_lvl;
	logic [LOCW-1:0]     wr_loc;
	entry_t              wr_ent;
	logic                ram_we;
	logic [IDW-1:0]      ram_waddr;
	logic [POSW-1:0]     ram_wdata;
	logic [POSW-1:0]     pos_rd;

	entry_t              lv_even [LEVELS];
	entry_t              lv_odd  [LEVELS];
	entry_t              rd_even_s;
	entry_t              rd_odd_s;
	entry_t              rd_one;

	logic                push_v;
	logic                flush_v;
	logic                aft_go;
	res_t                push_r;
	res_t                pend_q;
	logic                pend_v_q;
	logic                strobe_q;
	res_t                out_q;
	logic                last_q;

	logic [LVLW-1:0]     pos_lvl;
	logic [LOCW-1:0]     pos_loc;
	logic                present;
	logic [CNTW-1:0]     n_cnt;
	logic [POSW-1:0]     n_idx;
	logic [CGW-1:0]      cg1;
	logic [CGW-1:0]      cg2;
	logic [CGW-1:0]      cnt_ext;
	logic                c1_in;
	logic                c2_in;
	logic                pick;
	entry_t              child;
	logic [POSW-1:0]     par_idx;
	logic [TIME_W-1:0]   pop_diff;
	logic                expired;
	logic [ID_W+22-1:0]  id_ext;

	// row of level cells holding the heap
	for (genvar k = 0; k < LEVELS; k++) begin : g_level
		localparam int FIRST = (1 << k) - 1;
		localparam int LASTI = ((1 << (k + 1)) - 2 < HEAP_CAPACITY - 1) ?
			(1 << (k + 1)) - 2 : HEAP_CAPACITY - 1;
		imhtq_level #(
			.SIZE(LASTI - FIRST + 1),
			.LOCW(LOCW)
		) u_level (
			.clk    (clk),
			.wr_en  (wr_en && (wr_lvl == LVLW'(k))),
			.wr_loc (wr_loc),
			.wr_data(wr_ent),
			.rd_loc (rd_loc),
			.rd_even(lv_even[k]),
			.rd_odd (lv_odd[k])
		);
	end

	assign rd_even_s = lv_even[rd_lvl];
	assign rd_odd_s  = lv_odd[rd_lvl];
	assign rd_one    = rd_loc[0] ? rd_odd_s : rd_even_s;

	// id to heap slot map
	imhtq_ram #(
		.WIDTH(POSW),
		.DEPTH(ID_DEPTH)
	) u_pos (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(timer_id[IDW-1:0]),
		.rdata(pos_rd)
	);

	// address and compare helpers
	assign id_ext   = {22'd0, timer_id};
	assign pos_lvl  = lvl_of(pos_rd);
	assign pos_loc  = loc_of(pos_rd, pos_lvl);
	assign present  = idok_q && (CNTW'(pos_rd) < cnt_q) && (rd_one.owner == id_q);
	assign n_cnt    = cnt_q - CNTW'(1);
	assign n_idx    = n_cnt[POSW-1:0];
	assign cg1      = {1'b0, g_q, 1'b1};
	assign cg2      = {1'b0, g_q, 1'b0} + CGW'(2);
	assign cnt_ext  = CGW'(cnt_q);
	assign c1_in    = cg1 < cnt_ext;
	assign c2_in    = cg2 < cnt_ext;
	assign pick     = c2_in && earlier(rd_odd_s.expiry, rd_even_s.expiry);
	assign child    = pick ? rd_odd_s : rd_even_s;
	assign par_idx  = (g_q - POSW'(1)) >> 1;
	assign pop_diff = rd_one.expiry - now_q;
	assign expired  = (cnt_q != '0) && ((pop_diff == '0) || pop_diff[TIME_W-1]);

	// sequencer
	always_comb begin
		state_d   = state_q;
		op_d      = op_q;
		id_d      = id_q;
		exp_d     = exp_q;
		now_d     = now_q;
		idok_d    = idok_q;
		e_d       = e_q;
		cnt_d     = cnt_q;
		g_d       = g_q;
		lvl_d     = lvl_q;
		loc_d     = loc_q;
		moved_d   = moved_q;
		after_d   = after_q;
		fid_d     = fid_q;
		rd_lvl    = '0;
		rd_loc    = '0;
		wr_en     = 1'b0;
		wr_lvl    = lvl_q;
		wr_loc    = loc_q;
		wr_ent    = e_q;
		ram_we    = 1'b0;
		ram_waddr = e_q.owner[IDW-1:0];
		ram_wdata = g_q;
		push_v    = 1'b0;
		push_r    = '0;
		flush_v   = 1'b0;
		aft_go    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					op_d   = operation;
					id_d   = timer_id;
					exp_d  = now_ms + {1'b0, timeout_ms};
					now_d  = now_ms;
					idok_d = id_ext < 32'(ID_COUNT);
					case (operation)
						OP_ADD, OP_ADJ, OP_FIRE: begin
							state_d = ST_LOOK;
						end
						OP_TICK, OP_QUERY: begin
							state_d = ST_POP;
						end
						OP_CLEAR: begin
							cnt_d       = '0;
							push_v      = 1'b1;
							push_r.kind = KIND_DONE;
							state_d     = ST_DONE;
						end
						default: begin
							push_v      = 1'b1;
							push_r.kind = KIND_DONE;
							state_d     = ST_DONE;
						end
					endcase
				end
			end
			ST_LOOK: begin
				rd_lvl  = pos_lvl;
				rd_loc  = pos_loc;
				e_d     = '{expiry: exp_q, owner: id_q};
				moved_d = 1'b0;
				after_d = AFT_DONE;
				case (op_q)
					OP_ADD: begin
						if (!idok_q) begin
							push_v      = 1'b1;
							push_r.kind = KIND_UNKNOWN;
							state_d     = ST_DONE;
						end else if (present) begin
							g_d     = pos_rd;
							lvl_d   = pos_lvl;
							loc_d   = pos_loc;
							state_d = ST_SD;
						end else if (cnt_q >= CNTW'(HEAP_CAPACITY)) begin
							push_v      = 1'b1;
							push_r.kind = KIND_FULL;
							state_d     = ST_DONE;
						end else begin
							g_d     = cnt_q[POSW-1:0];
							lvl_d   = lvl_of(cnt_q[POSW-1:0]);
							loc_d   = loc_of(cnt_q[POSW-1:0], lvl_of(cnt_q[POSW-1:0]));
							cnt_d   = cnt_q + CNTW'(1);
							state_d = ST_SU;
						end
					end
					OP_ADJ, OP_FIRE: begin
						if (present) begin
							g_d   = pos_rd;
							lvl_d = pos_lvl;
							loc_d = pos_loc;
							if (op_q == OP_FIRE) begin
								fid_d   = id_q;
								after_d = AFT_FIRE;
								state_d = ST_REM;
							end else begin
								state_d = ST_SD;
							end
						end else begin
							push_v      = 1'b1;
							push_r.kind = KIND_UNKNOWN;
							state_d     = ST_DONE;
						end
					end
					default: begin
						push_v      = 1'b1;
						push_r.kind = KIND_DONE;
						state_d     = ST_DONE;
					end
				endcase
			end
			ST_REM: begin
				// move the last entry into the hole, or just drop the tail
				rd_lvl = lvl_of(n_idx);
				rd_loc = loc_of(n_idx, lvl_of(n_idx));
				cnt_d  = n_cnt;
				if (g_q < n_idx) begin
					e_d     = rd_one;
					moved_d = 1'b0;
					state_d = ST_SD;
				end else begin
					aft_go = 1'b1;
				end
			end
			ST_SD: begin
				rd_lvl = lvl_q + LVLW'(1);
				rd_loc = LOCW'({loc_q, 1'b0});
				if (!c1_in || earlier(e_q.expiry, child.expiry)) begin
					state_d = moved_q ? ST_FIN : ST_SU;
				end else begin
					// lift the smaller child into the hole
					wr_en     = 1'b1;
					wr_ent    = child;
					ram_we    = 1'b1;
					ram_waddr = child.owner[IDW-1:0];
					ram_wdata = g_q;
					g_d       = pick ? cg2[POSW-1:0] : cg1[POSW-1:0];
					lvl_d     = lvl_q + LVLW'(1);
					loc_d     = LOCW'({loc_q, pick});
					moved_d   = 1'b1;
				end
			end
			ST_SU: begin
				rd_lvl = lvl_q - LVLW'(1);
				rd_loc = loc_q >> 1;
				if ((g_q == '0) || earlier(rd_one.expiry, e_q.expiry)) begin
					state_d = ST_FIN;
				end else begin
					// lower the parent into the hole
					wr_en     = 1'b1;
					wr_ent    = rd_one;
					ram_we    = 1'b1;
					ram_waddr = rd_one.owner[IDW-1:0];
					ram_wdata = g_q;
					g_d       = par_idx;
					lvl_d     = lvl_q - LVLW'(1);
					loc_d     = loc_q >> 1;
				end
			end
			ST_FIN: begin
				wr_en  = 1'b1;
				ram_we = 1'b1;
				aft_go = 1'b1;
			end
			ST_POP: begin
				if (expired) begin
					fid_d   = rd_one.owner;
					g_d     = '0;
					lvl_d   = '0;
					loc_d   = '0;
					after_d = AFT_POP;
					state_d = ST_REM;
				end else begin
					state_d = ST_DONE;
					if (op_q == OP_QUERY) begin
						if (cnt_q != '0) begin
							push_v       = 1'b1;
							push_r.kind  = KIND_DELAY;
							push_r.delay = pop_diff[TIME_W-1] ? '0 : pop_diff[TIMEOUT_W-1:0];
						end else if (!pend_v_q) begin
							push_v      = 1'b1;
							push_r.kind = KIND_DELAY;
						end
					end else if (!pend_v_q) begin
						push_v      = 1'b1;
						push_r.kind = KIND_DONE;
					end
				end
			end
			ST_DONE: begin
				flush_v = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		// report the result once the heap is settled; a pop goes back to check the next timer
		if (aft_go) begin
			push_v = 1'b1;
			case (after_q)
				AFT_FIRE: begin
					push_r.kind = KIND_FIRED;
					push_r.id   = fid_q;
					state_d     = ST_DONE;
				end
				AFT_POP: begin
					push_r.kind = KIND_FIRED;
					push_r.id   = fid_q;
					state_d     = ST_POP;
				end
				default: begin
					push_r.kind = KIND_DONE;
					state_d     = ST_DONE;
				end
			endcase
		end
		push_r.empty = (cnt_d == '0);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			pend_v_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			strobe_q <= (push_v && pend_v_q) || flush_v;
			if (push_v) begin
				pend_v_q <= 1'b1;
			end else if (flush_v) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	// working registers, held result and output item
	always_ff @(posedge clk) begin
		op_q    <= op_d;
		id_q    <= id_d;
		exp_q   <= exp_d;
		now_q   <= now_d;
		idok_q  <= idok_d;
		e_q     <= e_d;
		g_q     <= g_d;
		lvl_q   <= lvl_d;
		loc_q   <= loc_d;
		moved_q <= moved_d;
		after_q <= after_d;
		fid_q   <= fid_d;
		if (push_v) begin
			out_q  <= pend_q;
			last_q <= 1'b0;
			pend_q <= push_r;
		end else if (flush_v) begin
			out_q  <= pend_q;
			last_q <= 1'b1;
		end
	end

	assign busy          = (state_q != ST_IDLE);
	assign result_strobe = strobe_q;
	assign kind          = out_q.kind;
	assign out_id        = out_q.id;
	assign delay_ms      = out_q.delay;
	assign queue_empty   = out_q.empty;
	assign last          = last_q;

	// checks
	`IMHTQ_ASSERT_IMP(a_last_frees, result_strobe && last, !busy)
	`IMHTQ_ASSERT_IMP(a_mid_busy, result_strobe && !last, busy)
	`IMHTQ_ASSERT_NXT(a_take_busy, start && !busy, busy)
	`IMHTQ_ASSERT_IMP(a_cnt_cap, 1'b1, cnt_q <= CNTW'(HEAP_CAPACITY))

endmodule

`default_nettype wire
